FILE: design/mqfs_pkg.sv
// Shared types and codes for the multi-queue FIFO with search.
package mqfs_pkg;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_SEARCH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ALLOC,
        S_PUSH_WR,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_HEAD_DONE,
        S_SRCH_RD,
        S_SRCH_WAIT,
        S_SRCH_STEP,
        S_FLUSH_PICK,
        S_FLUSH_RD,
        S_FLUSH_WAIT,
        S_FLUSH_STEP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic alloc_scan;
        logic push_write;
        logic rd_head;
        logic head_take;
        logic pop_commit;
        logic rd_walk;
        logic walk_step;
        logic flush_pick;
        logic flush_rd;
        logic flush_step;
        logic set_status;
        logic [1:0] status_code;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic       q_on;
        logic       q_empty;
        logic       pool_full;
        logic       alloc_done;
        logic       walk_last;
        logic       flush_any;
        logic       flush_last;
        logic [1:0] mode;
    } stat_t;

endpackage

FILE: design/mqfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mqfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/mqfs_ctrl.sv
// Controller state machine sequencing each queue operation.
module mqfs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            cfg_pending,
    input  mqfs_pkg::stat_t stat,
    output mqfs_pkg::ctrl_t ctrl,
    output logic            busy
);
    import mqfs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_pending)
                begin
                    state_next = S_FLUSH_PICK;
                end
                else if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.q_on)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (stat.mode)
                        MODE_PUSH:   state_next = stat.pool_full ? S_DONE : S_ALLOC;
                        MODE_SEARCH: state_next = stat.q_empty ? S_DONE : S_SRCH_RD;
                        default:     state_next = stat.q_empty ? S_DONE : S_HEAD_RD;
                    endcase
                end
            end
            S_ALLOC:      state_next = stat.alloc_done ? S_PUSH_WR : S_ALLOC;
            S_PUSH_WR:    state_next = S_DONE;
            S_HEAD_RD:    state_next = S_HEAD_WAIT;
            S_HEAD_WAIT:  state_next = S_HEAD_DONE;
            S_HEAD_DONE:  state_next = S_DONE;
            S_SRCH_RD:    state_next = S_SRCH_WAIT;
            S_SRCH_WAIT:  state_next = S_SRCH_STEP;
            S_SRCH_STEP:  state_next = stat.walk_last ? S_DONE : S_SRCH_WAIT;
            S_FLUSH_PICK: state_next = stat.flush_any ? S_FLUSH_RD : S_IDLE;
            S_FLUSH_RD:   state_next = S_FLUSH_WAIT;
            S_FLUSH_WAIT: state_next = S_FLUSH_STEP;
            S_FLUSH_STEP: state_next = stat.flush_last ? S_FLUSH_PICK : S_FLUSH_WAIT;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.latch_in = start && !cfg_pending;
            end
            S_CHECK:
            begin
                ctrl.set_status = 1'b1;
                if (!stat.q_on)
                begin
                    ctrl.status_code = ST_DISABLED;
                end
                else if (stat.mode == MODE_PUSH)
                begin
                    ctrl.status_code = stat.pool_full ? ST_FULL : ST_OK;
                end
                else if (stat.mode != MODE_SEARCH && stat.q_empty)
                begin
                    ctrl.status_code = ST_EMPTY;
                end
                else
                begin
                    ctrl.status_code = ST_OK;
                end
            end
            S_ALLOC:      ctrl.alloc_scan = 1'b1;
            S_PUSH_WR:    ctrl.push_write = 1'b1;
            S_HEAD_RD:    ctrl.rd_head = 1'b1;
            S_HEAD_WAIT:  ctrl.head_take = 1'b1;
            S_HEAD_DONE:  ctrl.pop_commit = 1'b1;
            S_SRCH_RD:    ctrl.rd_walk = 1'b1;
            S_SRCH_WAIT:  ctrl.rd_walk = 1'b0;
            S_SRCH_STEP:  ctrl.walk_step = 1'b1;
            S_FLUSH_PICK: ctrl.flush_pick = 1'b1;
            S_FLUSH_RD:   ctrl.flush_rd = 1'b1;
            S_FLUSH_WAIT: ctrl.flush_rd = 1'b0;
            S_FLUSH_STEP: ctrl.flush_step = 1'b1;
            S_DONE:       ctrl.emit = 1'b1;
            default:      ctrl = '0;
        endcase
    end

    assign busy = (state_reg != S_IDLE) || cfg_pending;

`ifndef SYNTHESIS
    a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |=> !ctrl.emit)
        else $error("done strobe repeated");
    a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.latch_in |=> state_reg == S_CHECK)
        else $error("accepted transaction did not start");
    a_flush_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.flush_step |-> !ctrl.emit)
        else $error("result during flush");
`endif
endmodule

FILE: design/mqfs_dp.sv
// Datapath: queue descriptors, free map, pool memories and result registers.
module mqfs_dp #(
    parameter int QUEUE_COUNT  = 8,
    parameter int POOL_ENTRIES = 64,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mqfs_pkg::ctrl_t          ctrl,
    output mqfs_pkg::stat_t          stat,
    input  logic [1:0]               mode,
    input  logic [2:0]               queue_id,
    input  logic [31:0]              entry_address,
    input  logic [31:0]              entry_payload,
    input  logic [7:0]               enable_q,
    input  logic [7:0]               flush_mask,
    output logic                     flush_clear,
    output logic [2:0]               flush_qid,
    output logic [1:0]               status,
    output logic [31:0]              head_address,
    output logic [31:0]              head_payload,
    output logic                     found,
    output logic [5:0]               match_position,
    output logic [6:0]               count_after
);
    import mqfs_pkg::*;

    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int CW = $clog2(POOL_ENTRIES + 1);
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int AW = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
    localparam int DW = AW + 32 + PW;

    logic [PW-1:0] head_reg [QUEUE_COUNT];
    logic [PW-1:0] tail_reg [QUEUE_COUNT];
    logic [CW-1:0] cnt_reg  [QUEUE_COUNT];
    logic [POOL_ENTRIES-1:0] free_reg;

    logic [1:0]    mode_reg;
    logic [2:0]    qid_reg;
    logic [AW-1:0] addr_reg;
    logic [31:0]   pay_reg;
    logic [QW-1:0] qi;
    logic          q_valid;

    logic [PW-1:0] scan_reg;
    logic [PW-1:0] walk_ptr_reg;
    logic [CW-1:0] walk_n_reg;
    logic [2:0]    fq_reg;

    logic [1:0]    status_reg;
    logic [31:0]   haddr_reg;
    logic [31:0]   hpay_reg;
    logic          found_reg;
    logic [5:0]    pos_reg;

    logic [PW-1:0] ram_raddr;
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [DW-1:0] ram_rdata;
    logic          link_we;
    logic [PW-1:0] link_waddr;
    logic [PW-1:0] link_wdata;
    logic [PW-1:0] link_rdata;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_pay;
    logic [QW-1:0] fqi;
    logic [2:0]    fsel;
    logic          fany;

    assign qi      = QW'(qid_reg);
    assign q_valid = ({29'd0, qid_reg} < QUEUE_COUNT) && enable_q[qid_reg];
    assign fqi     = QW'(fq_reg);
    assign rd_addr = ram_rdata[DW-1 -: AW];
    assign rd_pay  = ram_rdata[PW +: 32];

    // Lowest pending flush bit among implemented queues.
    always_comb
    begin
        fsel = '0;
        fany = 1'b0;
        for (int i = 7; i >= 0; i--)
        begin
            if (flush_mask[i] && i < QUEUE_COUNT)
            begin
                fsel = 3'(i);
                fany = 1'b1;
            end
        end
    end

    // A pending queue that holds no entries is only cleared, never walked.
    assign stat.q_on       = q_valid;
    assign stat.q_empty    = (cnt_reg[qi] == '0);
    assign stat.pool_full  = (free_reg == '0);
    assign stat.alloc_done = free_reg[scan_reg];
    assign stat.walk_last  = (walk_n_reg + CW'(1) >= cnt_reg[qi]);
    assign stat.flush_any  = fany && (cnt_reg[QW'(fsel)] != '0);
    assign stat.flush_last = (walk_n_reg + CW'(1) >= cnt_reg[fqi]);
    assign stat.mode       = mode_reg;

    assign flush_clear = ctrl.flush_pick;
    assign flush_qid   = fsel;

    always_comb
    begin
        ram_raddr = walk_ptr_reg;
        if (ctrl.rd_head)
        begin
            ram_raddr = head_reg[qi];
        end
        else if (ctrl.rd_walk)
        begin
            ram_raddr = head_reg[qi];
        end
        else if (ctrl.flush_rd)
        begin
            ram_raddr = head_reg[fqi];
        end
        else if (ctrl.walk_step || ctrl.flush_step)
        begin
            ram_raddr = link_rdata;
        end
    end

    assign ram_we     = ctrl.push_write;
    assign ram_waddr  = scan_reg;
    assign ram_wdata  = {addr_reg, pay_reg, {PW{1'b0}}};
    assign link_we    = ctrl.push_write && (cnt_reg[qi] != '0);
    assign link_waddr = tail_reg[qi];
    assign link_wdata = scan_reg;

    mqfs_ram #(.WIDTH(DW), .DEPTH(POOL_ENTRIES)) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mqfs_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (ram_raddr),
        .rdata (link_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
            for (int i = 0; i < QUEUE_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctrl.push_write)
            begin
                free_reg[scan_reg] <= 1'b0;
                cnt_reg[qi]        <= cnt_reg[qi] + CW'(1);
            end
            if (ctrl.pop_commit && mode_reg == MODE_POP)
            begin
                free_reg[head_reg[qi]] <= 1'b1;
                cnt_reg[qi]            <= cnt_reg[qi] - CW'(1);
            end
            if (ctrl.flush_step)
            begin
                free_reg[walk_ptr_reg] <= 1'b1;
                if (stat.flush_last)
                begin
                    cnt_reg[fqi] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            mode_reg <= mode;
            qid_reg  <= queue_id;
            addr_reg <= entry_address[AW-1:0];
            pay_reg  <= entry_payload;
        end
        if (ctrl.set_status)
        begin
            status_reg <= ctrl.status_code;
            haddr_reg  <= '0;
            hpay_reg   <= '0;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
            walk_n_reg <= '0;
            scan_reg   <= '0;
        end
        if (ctrl.alloc_scan && !free_reg[scan_reg])
        begin
            scan_reg <= scan_reg + PW'(1);
        end
        if (ctrl.push_write)
        begin
            tail_reg[qi] <= scan_reg;
            if (cnt_reg[qi] == '0)
            begin
                head_reg[qi] <= scan_reg;
            end
        end
        if (ctrl.rd_head || ctrl.rd_walk)
        begin
            walk_ptr_reg <= head_reg[qi];
        end
        if (ctrl.head_take)
        begin
            haddr_reg <= 32'(rd_addr);
            hpay_reg  <= rd_pay;
        end
        if (ctrl.pop_commit && mode_reg == MODE_POP)
        begin
            head_reg[qi] <= link_rdata;
        end
        if (ctrl.walk_step)
        begin
            if (rd_addr == addr_reg)
            begin
                found_reg <= 1'b1;
                pos_reg   <= 6'(walk_n_reg);
            end
            walk_n_reg   <= walk_n_reg + CW'(1);
            walk_ptr_reg <= link_rdata;
        end
        if (ctrl.flush_pick)
        begin
            fq_reg     <= fsel;
            walk_n_reg <= '0;
        end
        if (ctrl.flush_rd)
        begin
            walk_ptr_reg <= head_reg[fqi];
        end
        if (ctrl.flush_step)
        begin
            walk_n_reg   <= walk_n_reg + CW'(1);
            walk_ptr_reg <= link_rdata;
        end
    end

    assign status         = status_reg;
    assign head_address   = haddr_reg;
    assign head_payload   = hpay_reg;
    assign found          = found_reg;
    assign match_position = pos_reg;
    assign count_after    = q_valid ? 7'(cnt_reg[qi]) : 7'd0;

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push_write |-> free_reg[scan_reg])
        else $error("push into a busy entry");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop_commit |-> cnt_reg[qi] != '0)
        else $error("pop from an empty queue");
    a_found_search: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit && found_reg |-> mode_reg == MODE_SEARCH)
        else $error("found set outside search");
`endif
endmodule

FILE: design/multi_queue_fifo_with_search_unit.sv
// Top level of the multi-queue FIFO with address search.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  command  | start, busy           | mode, queue_id, entry_address, entry_payload
//  result   | done (one cycle)      | status, head_address, head_payload, found,
//           |                       | match_position, count_after
//  config   | queue_enable_we       | queue_enable_wdata
//
// Push scans the free map upward from entry 0 for the first free entry and writes there.
// Pop and peek read the head entry; search compares the address of every queue entry.
// A disabled queue, an empty pop or peek, or a search of an empty queue answers without a memory read.
// Enabling queues walks each newly enabled queue and frees its entries, with busy high.
// After reset all queues are empty and disabled; results cannot be stalled.
module multi_queue_fifo_with_search_unit #(
    parameter int QUEUE_COUNT  = 8,
    parameter int POOL_ENTRIES = 64,
    parameter int ADDRESS_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [2:0]  queue_id,
    input  logic [31:0] entry_address,
    input  logic [31:0] entry_payload,
    input  logic        queue_enable_we,
    input  logic [7:0]  queue_enable_wdata,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] head_address,
    output logic [31:0] head_payload,
    output logic        found,
    output logic [5:0]  match_position,
    output logic [6:0]  count_after
);
    import mqfs_pkg::*;

    localparam logic [7:0] QUEUE_MASK =
        (QUEUE_COUNT >= 8) ? 8'hFF : 8'((1 << QUEUE_COUNT) - 1);

    ctrl_t      ctrl;
    stat_t      stat;
    logic [7:0] enable_reg;
    logic [7:0] flush_reg;
    logic       flush_clear;
    logic [2:0] flush_qid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            flush_reg  <= '0;
        end
        else
        begin
            if (queue_enable_we)
            begin
                enable_reg <= queue_enable_wdata;
                flush_reg  <= flush_reg
                              | (queue_enable_wdata & ~enable_reg & QUEUE_MASK);
            end
            else if (flush_clear)
            begin
                flush_reg[flush_qid] <= 1'b0;
            end
        end
    end

    mqfs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cfg_pending (flush_reg != '0),
        .stat        (stat),
        .ctrl        (ctrl),
        .busy        (busy)
    );

    mqfs_dp #(
        .QUEUE_COUNT  (QUEUE_COUNT),
        .POOL_ENTRIES (POOL_ENTRIES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .mode           (mode),
        .queue_id       (queue_id),
        .entry_address  (entry_address),
        .entry_payload  (entry_payload),
        .enable_q       (enable_reg),
        .flush_mask     (flush_reg),
        .flush_clear    (flush_clear),
        .flush_qid      (flush_qid),
        .status         (status),
        .head_address   (head_address),
        .head_payload   (head_payload),
        .found          (found),
        .match_position (match_position),
        .count_after    (count_after)
    );

    assign done = ctrl.emit;
endmodule

FILE: tb/multi_queue_fifo_with_search_unit_tb.sv
// Self-checking testbench for the multi-queue FIFO with address search.
module multi_queue_fifo_with_search_unit_tb;
    import mqfs_pkg::*;

    typedef struct packed {
        mode_t       op;
        logic [2:0]  qid;
        logic [31:0] addr;
        logic [31:0] pay;
    } command_t;

    typedef struct packed {
        status_t     st;
        logic [31:0] haddr;
        logic [31:0] hpay;
        logic        fnd;
        logic [5:0]  pos;
        logic [6:0]  cnt;
    } outcome_t;

    localparam int NQ = 8;
    localparam int NPOOL = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = '0;
    logic [2:0]  queue_id = '0;
    logic [31:0] entry_address = '0;
    logic [31:0] entry_payload = '0;
    logic        queue_enable_we = 1'b0;
    logic [7:0]  queue_enable_wdata = '0;
    logic        done;
    logic [1:0]  status;
    logic [31:0] head_address;
    logic [31:0] head_payload;
    logic        found;
    logic [5:0]  match_position;
    logic [6:0]  count_after;

    command_t pending_cmds[$];
    outcome_t outcomes_due[$];
    int errors = 0;
    int cmds_sent = 0;
    int results_seen = 0;
    int full_seen = 0;
    int hits_seen = 0;
    bit calm = 1'b0;

    logic [7:0]  enabled_mask = '0;
    logic [5:0]  q_head[NQ];
    logic [5:0]  q_tail[NQ];
    int          q_len[NQ];
    logic [5:0]  link[NPOOL];
    logic [31:0] slot_addr[NPOOL];
    logic [31:0] slot_pay[NPOOL];
    bit          slot_free[NPOOL];
    logic [31:0] keys[4];

    multi_queue_fifo_with_search_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .queue_id(queue_id),
        .entry_address(entry_address),
        .entry_payload(entry_payload),
        .queue_enable_we(queue_enable_we),
        .queue_enable_wdata(queue_enable_wdata),
        .done(done),
        .status(status),
        .head_address(head_address),
        .head_payload(head_payload),
        .found(found),
        .match_position(match_position),
        .count_after(count_after)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void release_queue(int q);
        logic [5:0] p;
        p = q_head[q];
        for (int n = 0; n < q_len[q]; n++)
        begin
            slot_free[p] = 1'b1;
            p = link[p];
        end
        q_len[q] = 0;
        q_head[q] = '0;
        q_tail[q] = '0;
    endfunction

    function automatic void set_enables(logic [7:0] v);
        logic [7:0] rising;
        rising = v & ~enabled_mask;
        for (int q = 0; q < NQ; q++)
        begin
            if (rising[q])
            begin
                release_queue(q);
            end
        end
        enabled_mask = v;
    endfunction

    function automatic outcome_t fifo_op_outcome(command_t c);
        outcome_t r;
        int e;
        int q;
        logic [5:0] p;
        r = '0;
        r.st = ST_OK;
        q = c.qid;
        if (!enabled_mask[q])
        begin
            r.st = ST_DISABLED;
            return r;
        end
        case (c.op)
            MODE_PUSH:
            begin
                for (e = 0; e < NPOOL && !slot_free[e]; e++)
                begin
                end
                if (e >= NPOOL)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    slot_free[e] = 1'b0;
                    slot_addr[e] = c.addr;
                    slot_pay[e] = c.pay;
                    link[e] = '0;
                    if (q_len[q] == 0)
                    begin
                        q_head[q] = e[5:0];
                    end
                    else
                    begin
                        link[q_tail[q]] = e[5:0];
                    end
                    q_tail[q] = e[5:0];
                    q_len[q]++;
                end
            end
            MODE_POP, MODE_PEEK:
            begin
                if (q_len[q] == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    p = q_head[q];
                    r.haddr = slot_addr[p];
                    r.hpay = slot_pay[p];
                    if (c.op == MODE_POP)
                    begin
                        slot_free[p] = 1'b1;
                        q_head[q] = link[p];
                        q_len[q]--;
                    end
                end
            end
            default:
            begin
                p = q_head[q];
                for (int n = 0; n < q_len[q]; n++)
                begin
                    if (slot_addr[p] == c.addr)
                    begin
                        r.fnd = 1'b1;
                        r.pos = n[5:0];
                    end
                    p = link[p];
                end
            end
        endcase
        r.cnt = q_len[q][6:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                outcomes_due.push_back(fifo_op_outcome(pending_cmds.pop_front()));
                cmds_sent++;
            end
            if (!start || !busy)
            begin
                if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 32))
                begin
                    start <= 1'b1;
                    mode <= pending_cmds[0].op;
                    queue_id <= pending_cmds[0].qid;
                    entry_address <= pending_cmds[0].addr;
                    entry_payload <= pending_cmds[0].pay;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, status);
                errors++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                check_field("status", want.st, status);
                check_field("head_address", want.haddr, head_address);
                check_field("head_payload", want.hpay, head_payload);
                check_field("found", want.fnd, found);
                check_field("match_position", want.pos, match_position);
                check_field("count_after", want.cnt, count_after);
                if (want.st == ST_FULL)
                begin
                    full_seen++;
                end
                if (want.fnd)
                begin
                    hits_seen++;
                end
            end
        end
    end

    task automatic add_cmd(mode_t op, int q, logic [31:0] a, logic [31:0] d);
        command_t c;
        c.op = op;
        c.qid = q[2:0];
        c.addr = a;
        c.pay = d;
        pending_cmds.push_back(c);
    endtask

    task automatic add_random(int n, int push_pct);
        int r;
        mode_t op;
        logic [31:0] a;
        for (int k = 0; k < 4; k++)
        begin
            keys[k] = $urandom;
        end
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < push_pct)
            begin
                op = MODE_PUSH;
            end
            else if (r < push_pct + (100 - push_pct) * 4 / 10)
            begin
                op = MODE_POP;
            end
            else if (r < push_pct + (100 - push_pct) * 6 / 10)
            begin
                op = MODE_PEEK;
            end
            else
            begin
                op = MODE_SEARCH;
            end
            a = ($urandom_range(99) < 60) ? keys[$urandom_range(3)] : $urandom;
            add_cmd(op, $urandom_range(NQ - 1), a, $urandom);
        end
    endtask

    task automatic write_enables(logic [7:0] v);
        wait (pending_cmds.size() == 0 && outcomes_due.size() == 0);
        repeat (20) @(posedge clk);
        wait (!busy && !start);
        @(posedge clk);
        queue_enable_we <= 1'b1;
        queue_enable_wdata <= v;
        set_enables(v);
        @(posedge clk);
        queue_enable_we <= 1'b0;
    endtask

    initial
    begin
        for (int q = 0; q < NQ; q++)
        begin
            q_head[q] = '0;
            q_tail[q] = '0;
            q_len[q] = 0;
        end
        for (int e = 0; e < NPOOL; e++)
        begin
            slot_free[e] = 1'b1;
            link[e] = '0;
            slot_addr[e] = '0;
            slot_pay[e] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        add_cmd(MODE_PUSH, 0, 32'h1, 32'h2);
        add_cmd(MODE_SEARCH, 7, 32'h0, 32'h0);
        add_cmd(MODE_POP, 5, 32'h0, 32'h0);
        write_enables(8'hFF);
        add_cmd(MODE_PEEK, 3, 32'h0, 32'h0);
        add_cmd(MODE_POP, 3, 32'h0, 32'h0);
        add_cmd(MODE_SEARCH, 3, 32'h0, 32'h0);
        add_cmd(MODE_PUSH, 3, 32'hFFFF_FFFF, 32'h0);
        add_cmd(MODE_PUSH, 3, 32'h0, 32'hFFFF_FFFF);
        add_cmd(MODE_PUSH, 3, 32'hFFFF_FFFF, 32'h1234_5678);
        add_cmd(MODE_SEARCH, 3, 32'hFFFF_FFFF, 32'h0);
        add_cmd(MODE_SEARCH, 3, 32'h0, 32'h0);
        add_cmd(MODE_SEARCH, 3, 32'hDEAD_BEEF, 32'h0);
        add_cmd(MODE_PEEK, 3, 32'h0, 32'h0);
        add_cmd(MODE_POP, 3, 32'h0, 32'h0);
        add_cmd(MODE_POP, 3, 32'h0, 32'h0);
        add_cmd(MODE_PUSH, 7, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        add_cmd(MODE_POP, 7, 32'h0, 32'h0);
        add_cmd(MODE_POP, 7, 32'h0, 32'h0);
        add_cmd(MODE_PUSH, 1, 32'h8000_0000, 32'h8000_0001);
        write_enables(8'h7E);
        add_cmd(MODE_PUSH, 7, 32'h1, 32'h1);
        add_cmd(MODE_PEEK, 1, 32'h0, 32'h0);

        calm = 1'b1;
        add_random(300, 75);
        write_enables(8'h5A);
        calm = 1'b0;
        add_random(300, 45);
        write_enables(8'hFF);
        add_random(300, 40);
        write_enables(8'h01);
        add_random(300, 55);
        write_enables(8'hA5);
        add_random(330, 50);

        wait (pending_cmds.size() == 0 && outcomes_due.size() == 0);
        repeat (200) @(posedge clk);
        $display("Ran %0d commands over six enable settings; checked %0d results,",
                 cmds_sent, results_seen);
        $display("including %0d pool-full pushes and %0d search hits.", full_seen, hits_seen);
        if (errors == 0 && outcomes_due.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Timeout with %0d results outstanding.", outcomes_due.size());
        $display("status: fail");
        $finish;
    end
endmodule
